[design/fpp_pkg.sv]
// ----------------------------------------------------------------------------
// fpp_pkg - shared types and constants of the framed packet parser
// Phase and status codes, the CRC-8/MAXIM byte update and the result record.
// ----------------------------------------------------------------------------
package fpp_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int RCV_W       = $clog2(MAX_PAYLOAD + 1);

	localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD);
	localparam logic [7:0]  SYNC_A  = 8'hAA;
	localparam logic [7:0]  SYNC_B  = 8'h55;
	localparam logic [7:0]  CRC_POLY = 8'h8C;

	typedef enum logic [3:0] {
		PH_SYNC_A  = 4'd0,
		PH_SYNC_B  = 4'd1,
		PH_VER     = 4'd2,
		PH_TYPE    = 4'd3,
		PH_SEQ     = 4'd4,
		PH_LEN_L   = 4'd5,
		PH_LEN_H   = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_CRC     = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_GOOD    = 2'd1,
		ST_CRC_ERR = 2'd2,
		ST_DROP    = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  version;
		logic [7:0]  ftype;
		logic [7:0]  seqnum;
		logic [15:0] length;
		logic [31:0] good;
		logic [31:0] crc_err;
		logic [31:0] dropped;
		logic [31:0] bytes;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// reflected CRC-8, one bit per step
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[design/fpp_if.sv]
// ----------------------------------------------------------------------------
// fpp_if - valid/ready channels of the framed packet parser
// Request channel (feed or read) and result channel.
// ----------------------------------------------------------------------------
interface fpp_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_in;
	logic [7:0] read_index;

	modport source(output valid, mode, byte_in, read_index, input ready);
	modport sink(input valid, mode, byte_in, read_index, output ready);
endinterface

interface fpp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  frame_version;
	logic [7:0]  frame_type;
	logic [7:0]  frame_sequence;
	logic [15:0] frame_length;
	logic [7:0]  read_data;
	logic [31:0] good_frame_count;
	logic [31:0] crc_error_count;
	logic [31:0] dropped_count;
	logic [31:0] byte_count;

	modport source(output valid, status, frame_version, frame_type, frame_sequence,
		frame_length, read_data, good_frame_count, crc_error_count, dropped_count,
		byte_count, input ready);
	modport sink(input valid, status, frame_version, frame_type, frame_sequence,
		frame_length, read_data, good_frame_count, crc_error_count, dropped_count,
		byte_count, output ready);
endinterface

[design/framed_packet_parser_crc8.sv]
// ----------------------------------------------------------------------------
// framed_packet_parser_crc8 - sync/length frame parser with CRC-8/MAXIM check
// Finds AA 55 framed packets in a byte stream and serves stored payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   request: one item per handshake. mode 0 feeds byte_in to the parser,
//     mode 1 reads payload byte read_index from the payload store.
//   result: exactly one item per request item, in order: status, header
//     fields, read data and the four wrapping counters after that item.
// Throughput: one item per cycle unless result.ready stalls the pipe. The
//   parser state and CRC update for a byte close at its accept edge; the
//   payload store is a RAM written at the accept edge and read through its
//   registered port. An item's result passes the RAM read stage (stage 1),
//   then the output register, before result.valid shows it.
// Stall: with result.ready low the output register holds, the RAM stage may
//   still take one more item; request.ready drops only when both are full.
// Reset: the parser returns to the sync search, header fields and counters
//   clear. The payload store is not cleared; no clearing pass runs.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc8 import fpp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fpp_req_if.sink      request,
	fpp_res_if.source    result
);

	logic       acc;
	logic       adv_o;
	res_t       res;
	logic       rd_hit;
	wr_t        wr;
	logic [7:0] ram_rd;

	// stage 1: result waiting for RAM data
	logic       v_s1;
	res_t       res_s1;
	logic       hit_s1;

	// output register
	logic       v_q;
	res_t       res_q;
	logic [7:0] rd_q;

	assign adv_o         = !v_q || result.ready;
	assign request.ready = !v_s1 || adv_o;
	assign acc           = request.valid && request.ready;

	fpp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.mode       (request.mode),
		.byte_in    (request.byte_in),
		.read_index (request.read_index),
		.res        (res),
		.rd_hit     (rd_hit),
		.wr         (wr)
	);

	// write and read never share an edge: one item per edge, one port each
	fpp_ram #(
		.DEPTH (MAX_PAYLOAD),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (acc && wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (acc && rd_hit),
		.raddr (ADDR_W'({8'h00, request.read_index})),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_o) begin
			v_s1 <= 1'b0;
		end
	end

	// RAM data holds while stage 1 waits, since no read issues without an accept
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
			hit_s1 <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (v_s1 && adv_o) begin
			v_q <= 1'b1;
		end else if (result.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_o) begin
			res_q <= res_s1;
			rd_q  <= hit_s1 ? ram_rd : 8'h00;
		end
	end

	assign result.valid            = v_q;
	assign result.status           = res_q.status;
	assign result.frame_version    = res_q.version;
	assign result.frame_type       = res_q.ftype;
	assign result.frame_sequence   = res_q.seqnum;
	assign result.frame_length     = res_q.length;
	assign result.read_data        = rd_q;
	assign result.good_frame_count = res_q.good;
	assign result.crc_error_count  = res_q.crc_err;
	assign result.dropped_count    = res_q.dropped;
	assign result.byte_count       = res_q.bytes;

`ifndef SYNTHESIS
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_o |=> v_s1)
		else $error("stage 1 item lost while output stalled");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!request.ready |-> v_s1 && v_q)
		else $error("request stalled with a free stage");

	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && request.mode |=> res_s1.status == ST_NONE)
		else $error("read item reported a frame status");

	a_bytes_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !request.mode && v_s1 |=> res_s1.bytes == $past(res_s1.bytes) + 32'd1)
		else $error("byte counter did not advance by one");
`endif

endmodule

[design/fpp_ram.sv]
// ----------------------------------------------------------------------------
// fpp_ram - simple dual-port synchronous RAM
// One write port, one read port with registered data and read enable.
// ----------------------------------------------------------------------------
module fpp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/fpp_parse.sv]
// ----------------------------------------------------------------------------
// fpp_parse - frame parser state machine, CRC and counters
// Advances once per accepted item and issues payload store writes.
// ----------------------------------------------------------------------------
module fpp_parse import fpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic       mode,
	input  logic [7:0] byte_in,
	input  logic [7:0] read_index,
	output res_t       res,
	output logic       rd_hit,
	output wr_t        wr
);

	phase_t           phase_q, phase_d;
	logic [7:0]       ver_q, typ_q, seq_q, crc_q;
	logic [15:0]      len_q;
	logic [RCV_W-1:0] rcv_q;
	logic [31:0]      good_q, cerr_q, drop_q, bytes_q;

	logic [7:0]       crc_d;
	logic [15:0]      len_d, len_full;
	logic [RCV_W-1:0] rcv_d, rcv_inc;
	logic [7:0]       crc_nx;

	assign crc_nx   = crc8_update((phase_q == PH_VER) ? 8'h00 : crc_q, byte_in);
	assign len_full = {byte_in, len_q[7:0]};
	assign rcv_inc  = rcv_q + 1'b1;
	assign rd_hit   = mode && ({8'h00, read_index} < len_q) && ({8'h00, read_index} < LEN_MAX);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (!mode) begin
			case (phase_q)
				PH_SYNC_A:  if (byte_in == SYNC_A) phase_d = PH_SYNC_B;
				PH_SYNC_B:  phase_d = (byte_in == SYNC_B) ? PH_VER : PH_SYNC_A;
				PH_VER:     phase_d = PH_TYPE;
				PH_TYPE:    phase_d = PH_SEQ;
				PH_SEQ:     phase_d = PH_LEN_L;
				PH_LEN_L:   phase_d = PH_LEN_H;
				PH_LEN_H: begin
					if (len_full > LEN_MAX) phase_d = PH_SYNC_A;
					else if (len_full == 16'h0000) phase_d = PH_CRC;
					else phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: if (16'(rcv_inc) >= len_q) phase_d = PH_CRC;
				PH_CRC:     phase_d = PH_SYNC_A;
				default:    phase_d = PH_SYNC_A;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		res.status   = ST_NONE;
		res.version  = ver_q;
		res.ftype    = typ_q;
		res.seqnum   = seq_q;
		res.length   = len_q;
		res.good     = good_q;
		res.crc_err  = cerr_q;
		res.dropped  = drop_q;
		res.bytes    = bytes_q;
		crc_d        = crc_q;
		len_d        = len_q;
		rcv_d        = rcv_q;
		wr.we        = 1'b0;
		wr.addr      = rcv_q[ADDR_W-1:0];
		wr.data      = byte_in;
		if (!mode) begin
			res.bytes = bytes_q + 32'd1;
			case (phase_q)
				PH_SYNC_A, PH_SYNC_B: begin
				end
				PH_VER: begin
					res.version = byte_in;
					crc_d       = crc_nx;
					rcv_d       = '0;
				end
				PH_TYPE: begin
					res.ftype = byte_in;
					crc_d     = crc_nx;
				end
				PH_SEQ: begin
					res.seqnum = byte_in;
					crc_d      = crc_nx;
				end
				PH_LEN_L: begin
					len_d = {8'h00, byte_in};
					crc_d = crc_nx;
				end
				PH_LEN_H: begin
					crc_d = crc_nx;
					if (len_full > LEN_MAX) begin
						res.dropped = drop_q + 32'd1;
						res.status  = ST_DROP;
						len_d       = 16'h0000;
						rcv_d       = '0;
					end else begin
						len_d = len_full;
					end
				end
				PH_PAYLOAD: begin
					wr.we = 1'b1;
					rcv_d = rcv_inc;
					crc_d = crc_nx;
				end
				PH_CRC: begin
					if (crc_q == byte_in) begin
						res.good   = good_q + 32'd1;
						res.status = ST_GOOD;
					end else begin
						res.crc_err = cerr_q + 32'd1;
						res.status  = ST_CRC_ERR;
					end
				end
				default: begin
					res.dropped = drop_q + 32'd1;
					res.status  = ST_DROP;
					len_d       = 16'h0000;
					rcv_d       = '0;
				end
			endcase
			res.length = len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC_A;
			ver_q   <= '0;
			typ_q   <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			rcv_q   <= '0;
			crc_q   <= '0;
			good_q  <= '0;
			cerr_q  <= '0;
			drop_q  <= '0;
			bytes_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			ver_q   <= res.version;
			typ_q   <= res.ftype;
			seq_q   <= res.seqnum;
			len_q   <= len_d;
			rcv_q   <= rcv_d;
			crc_q   <= crc_d;
			good_q  <= res.good;
			cerr_q  <= res.crc_err;
			drop_q  <= res.dropped;
			bytes_q <= res.bytes;
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for framed_packet_parser_crc8
// Feeds a byte stream of AA 55 framed packets, noise and payload reads through
// the request channel. A bench-side parser model predicts every result item,
// and the monitor compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import fpp_pkg::*;

	localparam logic MODE_FEED    = 1'b0;
	localparam logic MODE_READ    = 1'b1;
	localparam int   TOTAL_ITEMS  = 1450;
	localparam int   IDLE_LIMIT   = 2000;
	localparam int   DRAIN_CYCLES = 16;

	typedef struct {
		logic       mode;
		logic [7:0] byte_in;
		logic [7:0] read_index;
		bit         drain_before;
	} parser_req_t;

	typedef struct {
		status_t     status;
		logic [7:0]  version;
		logic [7:0]  ftype;
		logic [7:0]  seq;
		logic [15:0] length;
		logic [7:0]  read_data;
		logic [31:0] good;
		logic [31:0] crc_err;
		logic [31:0] dropped;
		logic [31:0] bytes_fed;
	} frame_result_t;

	logic clk;
	logic arst_n;

	fpp_req_if req_ch();
	fpp_res_if res_ch();

	framed_packet_parser_crc8 u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	// Request items waiting for the driver, and the result items they will cause.
	parser_req_t   pending_items[$];
	frame_result_t predicted_results[$];

	int sent_cnt    = 0;
	int checked_cnt = 0;
	int error_count = 0;
	int idle_cycles = 0;
	bit drain_next  = 1'b0;

	// Bench-side parser state, advanced as items are generated.
	phase_t      m_phase;
	logic [7:0]  m_ver;
	logic [7:0]  m_type;
	logic [7:0]  m_seq;
	logic [15:0] m_len;
	logic [8:0]  m_rcv;
	logic [7:0]  m_crc;
	logic [31:0] m_good;
	logic [31:0] m_crc_err;
	logic [31:0] m_dropped;
	logic [31:0] m_bytes;
	logic [7:0]  m_store[MAX_PAYLOAD];
	bit          m_written[MAX_PAYLOAD];

	// Driver and monitor pacing.
	int req_gap     = 0;
	int req_stretch = 0;
	bit req_quiet   = 1'b0;
	int res_stall   = 0;
	int res_stretch = 0;
	bit res_quiet   = 1'b0;

	// CRC-8/MAXIM, LSB first, one data bit per step.
	function automatic logic [7:0] crc8_maxim_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// Advance the parser model by one request item and return the result item.
	task automatic predict_parser(input parser_req_t it, output frame_result_t r);
		status_t    st;
		logic [7:0] rd;
		logic [7:0] b;
		st = ST_NONE;
		rd = 8'h00;
		b  = it.byte_in;
		if (it.mode == MODE_FEED) begin
			m_bytes = m_bytes + 1;
			case (m_phase)
				PH_SYNC_A: begin
					if (b == SYNC_A)
						m_phase = PH_SYNC_B;
				end
				PH_SYNC_B: begin
					// a wrong second sync byte is not retried as a first one
					if (b == SYNC_B)
						m_phase = PH_VER;
					else
						m_phase = PH_SYNC_A;
				end
				PH_VER: begin
					m_ver   = b;
					m_crc   = crc8_maxim_byte(8'h00, b);
					m_rcv   = '0;
					m_phase = PH_TYPE;
				end
				PH_TYPE: begin
					m_type  = b;
					m_crc   = crc8_maxim_byte(m_crc, b);
					m_phase = PH_SEQ;
				end
				PH_SEQ: begin
					m_seq   = b;
					m_crc   = crc8_maxim_byte(m_crc, b);
					m_phase = PH_LEN_L;
				end
				PH_LEN_L: begin
					m_len   = {8'h00, b};
					m_crc   = crc8_maxim_byte(m_crc, b);
					m_phase = PH_LEN_H;
				end
				PH_LEN_H: begin
					m_len = {b, m_len[7:0]};
					m_crc = crc8_maxim_byte(m_crc, b);
					if (m_len > LEN_MAX) begin
						m_dropped = m_dropped + 1;
						m_len     = '0;
						m_rcv     = '0;
						m_phase   = PH_SYNC_A;
						st        = ST_DROP;
					end else if (m_len == 16'd0) begin
						m_phase = PH_CRC;
					end else begin
						m_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (int'(m_rcv) < MAX_PAYLOAD) begin
						m_store[m_rcv[7:0]]   = b;
						m_written[m_rcv[7:0]] = 1'b1;
					end
					m_rcv = m_rcv + 9'd1;
					m_crc = crc8_maxim_byte(m_crc, b);
					if (int'(m_rcv) >= int'(m_len))
						m_phase = PH_CRC;
				end
				PH_CRC: begin
					if (m_crc == b) begin
						m_good = m_good + 1;
						st     = ST_GOOD;
					end else begin
						m_crc_err = m_crc_err + 1;
						st        = ST_CRC_ERR;
					end
					m_phase = PH_SYNC_A;
				end
				default: begin
					m_dropped = m_dropped + 1;
					m_len     = '0;
					m_rcv     = '0;
					m_phase   = PH_SYNC_A;
					st        = ST_DROP;
				end
			endcase
		end else if (int'(it.read_index) < int'(m_len) && int'(it.read_index) < MAX_PAYLOAD) begin
			rd = m_store[it.read_index];
		end
		r.status    = st;
		r.version   = m_ver;
		r.ftype     = m_type;
		r.seq       = m_seq;
		r.length    = m_len;
		r.read_data = rd;
		r.good      = m_good;
		r.crc_err   = m_crc_err;
		r.dropped   = m_dropped;
		r.bytes_fed = m_bytes;
	endtask

	// Queue one request item together with its predicted result item.
	task automatic push_item(input parser_req_t it);
		frame_result_t r;
		it.drain_before = drain_next;
		drain_next      = 1'b0;
		predict_parser(it, r);
		pending_items.push_back(it);
		predicted_results.push_back(r);
	endtask

	task automatic push_feed(input logic [7:0] b);
		parser_req_t it;
		it.mode       = MODE_FEED;
		it.byte_in    = b;
		it.read_index = 8'($urandom_range(0, 255));
		push_item(it);
	endtask

	task automatic push_read(input logic [7:0] idx);
		parser_req_t it;
		it.mode       = MODE_READ;
		it.byte_in    = 8'($urandom_range(0, 255));
		it.read_index = idx;
		push_item(it);
	endtask

	// Read a random position, steering clear of store entries never written.
	task automatic push_random_read();
		logic [7:0] idx;
		int         k;
		bit         ok;
		idx = 8'($urandom_range(0, 255));
		if (m_len != 16'd0 && $urandom_range(0, 1) == 1)
			idx = 8'($urandom_range(0, int'(m_len) - 1));
		ok = 1'b0;
		for (k = 0; k < MAX_PAYLOAD && !ok; k++) begin
			if (int'(idx) >= int'(m_len) || m_written[idx])
				ok = 1'b1;
			else
				idx = idx + 8'd1;
		end
		if (ok)
			push_read(idx);
	endtask

	// One frame, header only over LEN_MAX; bad_crc flips CRC bits, read_pct mixes reads into the payload.
	task automatic push_frame(input logic [7:0] ver, input logic [7:0] ftype,
			input logic [7:0] seq, input logic [15:0] len, input bit bad_crc,
			input int read_pct);
		logic [7:0] crc;
		logic [7:0] b;
		crc = 8'h00;
		push_feed(SYNC_A);
		push_feed(SYNC_B);
		push_feed(ver);
		crc = crc8_maxim_byte(crc, ver);
		push_feed(ftype);
		crc = crc8_maxim_byte(crc, ftype);
		push_feed(seq);
		crc = crc8_maxim_byte(crc, seq);
		push_feed(len[7:0]);
		crc = crc8_maxim_byte(crc, len[7:0]);
		push_feed(len[15:8]);
		crc = crc8_maxim_byte(crc, len[15:8]);
		if (len > LEN_MAX)
			return;
		for (int i = 0; i < int'(len); i++) begin
			if ($urandom_range(0, 99) < read_pct)
				push_random_read();
			// sync patterns inside the payload are plain data
			case ($urandom_range(0, 15))
				0:       b = SYNC_A;
				1:       b = SYNC_B;
				2:       b = 8'h00;
				3:       b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			push_feed(b);
			crc = crc8_maxim_byte(crc, b);
		end
		if (bad_crc)
			crc = crc ^ 8'($urandom_range(1, 255));
		push_feed(crc);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Request driver: present the next pending item once its gap has run out,
	// hold it until accepted. An item marked drain_before waits until every
	// result item already owed has come back.
	always @(posedge clk) begin : req_driver
		parser_req_t nxt;
		logic        fire;
		logic        busy;
		logic        load;
		fire = req_ch.valid && req_ch.ready;
		busy = req_ch.valid && !fire;
		load = 1'b0;
		if (fire)
			sent_cnt <= sent_cnt + 1;
		if (arst_n && !busy) begin
			if (req_gap > 0)
				req_gap = req_gap - 1;
			else if (pending_items.size() > 0)
				load = !pending_items[0].drain_before || (!fire && checked_cnt == sent_cnt);
		end
		if (load) begin
			nxt = pending_items.pop_front();
			req_ch.mode       <= nxt.mode;
			req_ch.byte_in    <= nxt.byte_in;
			req_ch.read_index <= nxt.read_index;
			// alternate stretches of back-to-back items with stretches of random gaps
			if (req_stretch == 0) begin
				req_quiet   = ($urandom_range(0, 3) == 0);
				req_stretch = $urandom_range(16, 64);
			end
			req_stretch = req_stretch - 1;
			req_gap     = req_quiet ? 0 : $urandom_range(0, 8);
		end
		if (!busy)
			req_ch.valid <= load;
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	// Result monitor: compare each accepted result item with the oldest
	// prediction, then stall ready for a drawn number of cycles.
	always @(posedge clk) begin : res_monitor
		frame_result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (checked_cnt >= sent_cnt) begin
				$error("result item with no request item outstanding");
				error_count++;
			end else begin
				want = predicted_results.pop_front();
				check_field("status", 32'(want.status), 32'(res_ch.status));
				check_field("frame_version", 32'(want.version), 32'(res_ch.frame_version));
				check_field("frame_type", 32'(want.ftype), 32'(res_ch.frame_type));
				check_field("frame_sequence", 32'(want.seq), 32'(res_ch.frame_sequence));
				check_field("frame_length", 32'(want.length), 32'(res_ch.frame_length));
				check_field("read_data", 32'(want.read_data), 32'(res_ch.read_data));
				check_field("good_frame_count", want.good, res_ch.good_frame_count);
				check_field("crc_error_count", want.crc_err, res_ch.crc_error_count);
				check_field("dropped_count", want.dropped, res_ch.dropped_count);
				check_field("byte_count", want.bytes_fed, res_ch.byte_count);
				checked_cnt <= checked_cnt + 1;
			end
			if (res_stretch == 0) begin
				res_quiet   = ($urandom_range(0, 3) == 0);
				res_stretch = $urandom_range(16, 64);
			end
			res_stretch = res_stretch - 1;
			res_stall   = res_quiet ? 0 : $urandom_range(0, 8);
		end
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (res_stall > 0) begin
			res_stall = res_stall - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int         sel;
		int         r;
		int         n;
		int         big_frames;
		logic [15:0] len;

		// Drive every block input to a known value before the first edge.
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_FEED;
		req_ch.byte_in    = 8'h00;
		req_ch.read_index = 8'h00;
		res_ch.ready      = 1'b0;

		m_phase   = PH_SYNC_A;
		m_ver     = '0;
		m_type    = '0;
		m_seq     = '0;
		m_len     = '0;
		m_rcv     = '0;
		m_crc     = '0;
		m_good    = '0;
		m_crc_err = '0;
		m_dropped = '0;
		m_bytes   = '0;
		for (int i = 0; i < MAX_PAYLOAD; i++) begin
			m_store[i]   = 8'h00;
			m_written[i] = 1'b0;
		end
		big_frames = 0;

		// Directed: a wrong second sync byte that is itself 0xAA, then a
		// zero-length frame, a CRC error, a read of the kept payload and a
		// length just above the maximum.
		push_feed(SYNC_A);
		push_feed(SYNC_A);
		push_feed(SYNC_B);
		push_frame(8'h00, 8'hFF, 8'h80, 16'd0, 1'b0, 0);
		push_frame(8'hFF, 8'h00, 8'h7F, 16'd1, 1'b1, 0);
		push_read(8'd0);
		push_frame(8'h01, 8'h02, 8'h03, LEN_MAX + 16'd1, 1'b0, 0);

		// Random: mostly well-formed frames, plus noise, reads and cut-off headers.
		drain_next = 1'b1;
		while (pending_items.size() < TOTAL_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				drain_next = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				r = $urandom_range(0, 99);
				if (r == 0)
					len = 16'hFFFF;
				else if (r == 1)
					len = LEN_MAX + 16'd1;
				else if (r < 5)
					len = 16'($urandom_range(int'(LEN_MAX) + 1, 65535));
				else if (r < 15)
					len = 16'd0;
				else if (r < 85)
					len = 16'($urandom_range(1, 16));
				else if (r < 97)
					len = 16'($urandom_range(17, 64));
				else if (big_frames < 2) begin
					len = (big_frames == 0) ? LEN_MAX : LEN_MAX - 16'd1;
					big_frames++;
				end else
					len = 16'($urandom_range(65, 128));
				push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), len, ($urandom_range(0, 99) < 20),
					($urandom_range(0, 1) == 1) ? 10 : 0);
			end else if (sel < 82) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_feed(($urandom_range(0, 2) == 0) ? SYNC_A : 8'($urandom_range(0, 255)));
			end else if (sel < 94) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_random_read();
			end else begin
				// cut-off header; what follows is taken as its remainder
				push_feed(SYNC_A);
				push_feed(SYNC_B);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					push_feed(8'($urandom_range(0, 255)));
			end
		end

		// Hold reset, then release it once.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to go out and every result item to come back,
		// then linger to catch stray results.
		while (pending_items.size() > 0 || req_ch.valid || checked_cnt != sent_cnt)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && checked_cnt == sent_cnt)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
design/fpp_pkg.sv
design/fpp_if.sv
design/fpp_ram.sv
design/fpp_parse.sv
design/framed_packet_parser_crc8.sv
tb/tb_top.sv
